// ----- hdl/mfpe_pkg.sv -----
package mfpe_pkg;

    localparam int CMD_W   = 3;
    localparam int COORD_W = 8;
    localparam int DATA_W  = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_PIXEL   = 3'd0,
        CMD_SET_PIXEL    = 3'd1,
        CMD_CLEAR_PIXEL  = 3'd2,
        CMD_TOGGLE_PIXEL = 3'd3,
        CMD_CLEAR_SCREEN = 3'd4,
        CMD_READ_COLUMN  = 3'd5
    } cmd_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

// ----- hdl/mfpe_if.sv -----
interface mfpe_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [mfpe_pkg::CMD_W-1:0]     command;
    logic [mfpe_pkg::COORD_W-1:0]   x;
    logic [mfpe_pkg::COORD_W-1:0]   y;

    modport source (output valid, command, x, y, input ready);
    modport sink (input valid, command, x, y, output ready);
endinterface

interface mfpe_res_if;
    logic                           valid;
    logic                           ready;
    logic                           pixel_on;
    logic [mfpe_pkg::DATA_W-1:0]    column_data;
    logic                           in_range;

    modport source (output valid, pixel_on, column_data, in_range, input ready);
    modport sink (input valid, pixel_on, column_data, in_range, output ready);
endinterface

// ----- hdl/mfpe_ram.sv -----
module mfpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/mono_framebuffer_pixel_engine.sv -----
// a command and its column read are registered on accept; execute waits
// until no result is unread; one command at a time, read then write-back
// of a column word through the single frame memory port pair
// reset: asynchronous, clears control and all column valid flags, so the
// store reads blank; clear screen drops all the flags at once
module mono_framebuffer_pixel_engine #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    mfpe_cmd_if.sink           cmd,
    mfpe_res_if.source         res
);
    import mfpe_pkg::*;

    localparam int AW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [AW-1:0]       x_reg;
    logic [RW-1:0]       y_reg;
    logic                col_ok_reg;
    logic                pix_ok_reg;
    logic [COLUMNS-1:0]  fill_reg, fill_next;

    logic                res_valid_reg;
    logic                pixel_on_reg;
    logic [DATA_W-1:0]   column_data_reg;
    logic                in_range_reg;

    logic                accept;
    logic                done;
    logic                col_ok;
    logic                pix_ok;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [ROWS-1:0]     rd_data;
    logic [ROWS-1:0]     word;
    logic [ROWS-1:0]     mask;
    logic                wr_en;
    logic [ROWS-1:0]     wr_data;
    logic                pixel_on_next;
    logic [DATA_W-1:0]   column_data_next;
    logic                in_range_next;

    assign col_ok = {1'b0, cmd.x} < (COORD_W + 1)'(COLUMNS);
    assign pix_ok = col_ok && ({1'b0, cmd.y} < (COORD_W + 1)'(ROWS));
    assign accept = cmd.valid && cmd.ready;
    assign rd_addr = col_ok ? cmd.x[AW-1:0] : '0;

    mfpe_ram #(
        .WIDTH (ROWS),
        .DEPTH (COLUMNS)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (x_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // a column never written since the last clear reads as blank
    assign word = fill_reg[x_reg] ? rd_data : '0;
    assign mask = ROWS'(1) << y_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.ready        = 1'b0;
        rd_en            = 1'b0;
        done             = 1'b0;
        wr_en            = 1'b0;
        wr_data          = word;
        pixel_on_next    = 1'b0;
        column_data_next = '0;
        in_range_next    = 1'b0;
        fill_next        = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                rd_en     = 1'b1;
            end
            ST_EXEC:
            begin
                done = !res_valid_reg || res.ready;
                case (cmd_reg)
                    CMD_READ_PIXEL:
                    begin
                        pixel_on_next = pix_ok_reg && ((word & mask) != '0);
                        in_range_next = pix_ok_reg;
                    end
                    CMD_SET_PIXEL:
                    begin
                        wr_en         = pix_ok_reg;
                        wr_data       = word | mask;
                        in_range_next = pix_ok_reg;
                    end
                    CMD_CLEAR_PIXEL:
                    begin
                        wr_en         = pix_ok_reg;
                        wr_data       = word & ~mask;
                        in_range_next = pix_ok_reg;
                    end
                    CMD_TOGGLE_PIXEL:
                    begin
                        wr_en         = pix_ok_reg;
                        wr_data       = word ^ mask;
                        in_range_next = pix_ok_reg;
                    end
                    CMD_CLEAR_SCREEN:
                    begin
                        fill_next     = '0;
                        in_range_next = 1'b1;
                    end
                    CMD_READ_COLUMN:
                    begin
                        column_data_next = col_ok_reg ? DATA_W'(word) : '0;
                        in_range_next    = col_ok_reg;
                    end
                    default:
                    begin
                        in_range_next = 1'b0;
                    end
                endcase
                wr_en = wr_en && done;
                if (wr_en)
                begin
                    fill_next[x_reg] = 1'b1;
                end
                if (!done)
                begin
                    fill_next = fill_reg;
                end
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(cmd.command);
            x_reg      <= rd_addr;
            y_reg      <= cmd.y[RW-1:0];
            col_ok_reg <= col_ok;
            pix_ok_reg <= pix_ok;
        end
        if (done)
        begin
            pixel_on_reg    <= pixel_on_next;
            column_data_reg <= column_data_next;
            in_range_reg    <= in_range_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.pixel_on    = pixel_on_reg;
    assign res.column_data = column_data_reg;
    assign res.in_range    = in_range_reg;

    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("command word accepted without entering execute");

    a_clear_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cmd_reg == CMD_CLEAR_SCREEN) |=> fill_reg == '0)
        else $error("clear screen left columns marked written");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.in_range) |-> (!res.pixel_on && res.column_data == '0))
        else $error("out-of-range result carries data");

    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> res.valid)
        else $error("finished command produced no result word");

endmodule
